@@ hdl/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue cell chain.
// ----------------------------------------------------------------------------
package deq_pkg;

    // Number of cells in the chain (words the queue can hold)
    localparam int CAPACITY = 16;
    localparam int WORD_W   = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int TOTAL_W  = 5;

    // Request codes carried on the slave tuser
    typedef enum logic [1:0] {
        ACT_PUSH_FRONT = 2'd0,
        ACT_POP_FRONT  = 2'd1,
        ACT_PUSH_REAR  = 2'd2,
        ACT_POP_REAR   = 2'd3
    } t_action;

    // Result status codes carried on the master tuser
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic push_front;
        logic pop_front;
        logic push_rear;
        logic pop_rear;
    } t_cell_ctrl;

    // One result word before it enters the output stage
    typedef struct packed {
        t_status                   status;
        logic signed [WORD_W-1:0]  removed;
        logic [TOTAL_W-1:0]        total;
    } t_result;

endpackage

@@ hdl/deq_cell.sv @@
// ----------------------------------------------------------------------------
// deq_cell
// One storage cell of the deque chain. Cell 0 holds the front word; each
// cell trades its word with the left or right neighbor on a front push or
// pop, and loads or drops its word when it sits at the rear boundary.
// ----------------------------------------------------------------------------
module deq_cell (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  deq_pkg::t_cell_ctrl                i_ctrl,
    input  logic signed [deq_pkg::WORD_W-1:0]  i_value,
    input  logic signed [deq_pkg::WORD_W-1:0]  i_left_data,
    input  logic                               i_left_valid,
    input  logic signed [deq_pkg::WORD_W-1:0]  i_right_data,
    input  logic                               i_right_valid,
    output logic signed [deq_pkg::WORD_W-1:0]  o_data,
    output logic                               o_valid,
    output logic signed [deq_pkg::WORD_W-1:0]  o_rear_data
);

    logic signed [deq_pkg::WORD_W-1:0] r_data;
    logic signed [deq_pkg::WORD_W-1:0] n_data;
    logic                              r_valid;
    logic                              n_valid;
    logic                              w_is_rear;
    logic                              w_is_slot;

    // Locate the rear boundary from the neighbors
    assign w_is_rear = r_valid && !i_right_valid;
    assign w_is_slot = !r_valid && i_left_valid;

    // Pick the next word for this cell
    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        if (i_ctrl.push_front) begin
            n_data  = i_left_data;
            n_valid = i_left_valid;
        end else if (i_ctrl.pop_front) begin
            n_data  = i_right_data;
            n_valid = i_right_valid;
        end else if (i_ctrl.push_rear && w_is_slot) begin
            n_data  = i_value;
            n_valid = 1'b1;
        end else if (i_ctrl.pop_rear && w_is_rear) begin
            n_valid = 1'b0;
        end
    end

    // Hold occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Hold the word
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data      = r_data;
    assign o_valid     = r_valid;
    assign o_rear_data = w_is_rear ? r_data : '0;

endmodule

@@ hdl/deq_skid.sv @@
// ----------------------------------------------------------------------------
// deq_skid
// Output register with a skid stage: takes a new result while the previous
// one still waits on the master side.
// ----------------------------------------------------------------------------
module deq_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  deq_pkg::t_result  i_in_result,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output deq_pkg::t_result  o_out_result
);

    logic             r_out_valid;
    logic             r_skid_valid;
    deq_pkg::t_result r_out;
    deq_pkg::t_result r_skid;
    logic             w_in_take;
    logic             w_out_free;

    assign o_in_ready = !r_skid_valid;
    assign w_in_take  = i_in_valid && !r_skid_valid;
    assign w_out_free = !r_out_valid || i_out_ready;

    // Advance valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid  <= r_skid_valid || w_in_take;
            r_skid_valid <= 1'b0;
        end else if (w_in_take) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Move payloads: skid drains first, else the new word lands in the stalled slot
    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out <= r_skid_valid ? r_skid : i_in_result;
        end else if (w_in_take) begin
            r_skid <= i_in_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_result = r_out;

endmodule

@@ hdl/double_ended_queue_top.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Output: each result word is registered in the two-entry output stage.
// Throughput: one request per cycle; each cell of the chain updates in the
// same cycle, and the two-entry output stage stalls the input only when both
// entries hold words that the master side has not taken.
// Reset: synchronous active-low reset empties every cell and both output
// entries; no clearing pass is needed.
// ----------------------------------------------------------------------------
module double_ended_queue_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] value
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] action
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [31:0] removed_value, [36:32] entry_total
    output logic [1:0]  o_m_axis_tuser    // [1:0] status
);

    localparam int N = deq_pkg::CAPACITY;

    logic signed [deq_pkg::WORD_W-1:0] w_cell_data [N];
    logic                              w_cell_valid [N];
    logic signed [deq_pkg::WORD_W-1:0] w_cell_rear [N];
    logic signed [deq_pkg::WORD_W-1:0] w_rear_word;
    logic signed [deq_pkg::WORD_W-1:0] w_value;
    deq_pkg::t_action                  w_action;
    deq_pkg::t_cell_ctrl               w_ctrl;
    deq_pkg::t_result                  w_result;
    logic                              w_in_ready;
    logic                              w_accept;
    logic                              w_full;
    logic                              w_empty;
    logic [deq_pkg::CNT_W-1:0]         r_held_count;
    logic [deq_pkg::CNT_W-1:0]         n_held_count;

    assign w_value  = $signed(i_s_axis_tdata);
    assign w_action = deq_pkg::t_action'(i_s_axis_tuser);
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_full   = (r_held_count == deq_pkg::CNT_W'(N));
    assign w_empty  = (r_held_count == '0);

    assign o_s_axis_tready = i_rst_n && w_in_ready;

    // Decode the request into cell commands and the result word
    always_comb begin
        w_ctrl          = '0;
        n_held_count    = r_held_count;
        w_result.status = deq_pkg::ST_OK;
        w_result.removed = '0;
        unique case (w_action)
            deq_pkg::ACT_PUSH_FRONT,
            deq_pkg::ACT_PUSH_REAR: begin
                if (w_full) begin
                    w_result.status = deq_pkg::ST_FULL;
                end else begin
                    w_ctrl.push_front = w_accept && (w_action == deq_pkg::ACT_PUSH_FRONT);
                    w_ctrl.push_rear  = w_accept && (w_action == deq_pkg::ACT_PUSH_REAR);
                    n_held_count      = r_held_count + deq_pkg::CNT_W'(1);
                end
            end
            deq_pkg::ACT_POP_FRONT: begin
                if (w_empty) begin
                    w_result.status = deq_pkg::ST_EMPTY;
                end else begin
                    w_ctrl.pop_front = w_accept;
                    w_result.removed = w_cell_data[0];
                    n_held_count     = r_held_count - deq_pkg::CNT_W'(1);
                end
            end
            deq_pkg::ACT_POP_REAR: begin
                if (w_empty) begin
                    w_result.status = deq_pkg::ST_EMPTY;
                end else begin
                    w_ctrl.pop_rear  = w_accept;
                    w_result.removed = w_rear_word;
                    n_held_count     = r_held_count - deq_pkg::CNT_W'(1);
                end
            end
            default: begin
                w_result.status = deq_pkg::ST_OK;
            end
        endcase
        w_result.total = deq_pkg::TOTAL_W'(n_held_count);
    end

    // Merge the rear taps; only one cell marks itself as rear
    always_comb begin
        w_rear_word = '0;
        for (int i = 0; i < N; i++) begin
            w_rear_word = w_rear_word | w_cell_rear[i];
        end
    end

    // Hold the word count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_count <= '0;
        end else if (w_accept) begin
            r_held_count <= n_held_count;
        end
    end

    // Build the cell chain; the front end sees the incoming word as its left neighbor
    for (genvar g = 0; g < N; g++) begin : g_cell
        logic signed [deq_pkg::WORD_W-1:0] w_left_data;
        logic                              w_left_valid;
        logic signed [deq_pkg::WORD_W-1:0] w_right_data;
        logic                              w_right_valid;

        if (g == 0) begin : g_front
            assign w_left_data  = w_value;
            assign w_left_valid = 1'b1;
        end else begin : g_inner_l
            assign w_left_data  = w_cell_data[g-1];
            assign w_left_valid = w_cell_valid[g-1];
        end

        if (g == N - 1) begin : g_back
            assign w_right_data  = '0;
            assign w_right_valid = 1'b0;
        end else begin : g_inner_r
            assign w_right_data  = w_cell_data[g+1];
            assign w_right_valid = w_cell_valid[g+1];
        end

        deq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_value       (w_value),
            .i_left_data   (w_left_data),
            .i_left_valid  (w_left_valid),
            .i_right_data  (w_right_data),
            .i_right_valid (w_right_valid),
            .o_data        (w_cell_data[g]),
            .o_valid       (w_cell_valid[g]),
            .o_rear_data   (w_cell_rear[g])
        );
    end

    deq_pkg::t_result w_out_result;

    deq_skid u_skid (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (w_accept),
        .i_in_result  (w_result),
        .o_in_ready   (w_in_ready),
        .o_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .o_out_result (w_out_result)
    );

    assign o_m_axis_tdata = {3'b000, w_out_result.total, w_out_result.removed};
    assign o_m_axis_tuser = w_out_result.status;

endmodule

@@ hdl/deq_checker.sv @@
// ----------------------------------------------------------------------------
// deq_checker
// Port-level checks for the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
module deq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [31:0] i_s_axis_tdata,
    input logic [1:0]  i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [39:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser
);

    // Every accepted request leaves a result word valid on the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> o_m_axis_tvalid)
        else $error("accepted request produced no result word");

    // Count never exceeds the chain length
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[36:32] <= 5'(deq_pkg::CAPACITY)))
        else $error("entry total beyond capacity");

    // A refused removal reports an empty queue and no data
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == deq_pkg::ST_EMPTY) |->
        (o_m_axis_tdata[36:0] == 37'd0))
        else $error("empty status with nonzero data or count");

    // A refused insert reports a full queue
    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == deq_pkg::ST_FULL) |->
        (o_m_axis_tdata[36:32] == 5'(deq_pkg::CAPACITY)) && (o_m_axis_tdata[31:0] == 32'd0))
        else $error("full status with wrong count or data");

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result word changed");

endmodule

bind double_ended_queue_top deq_checker u_deq_checker (.*);
